FILE: hdl/assert_macros.svh
// Assertion helpers shared by checker files. The enclosing scope provides
// clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define ASE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ase_checker: property violated");

// Check on every rising edge, reset included.
`define ASE_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("ase_checker: reset property violated");

`endif

FILE: hdl/ase_pkg.sv
package ase_pkg;

  // Fixed point format of times and levels.
  localparam int unsigned FRAC_WIDTH = 24;
  localparam int unsigned LVL_W      = FRAC_WIDTH + 1;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SMP_W      = 16;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned BLEN_W     = POS_W + 1;
  localparam int unsigned PH_W       = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [LVL_W-1:0]  ONE       = {1'b1, {FRAC_WIDTH{1'b0}}};
  localparam logic [BLEN_W-1:0] MAX_BLOCK = {1'b1, {POS_W{1'b0}}};

  // Serial arithmetic units.
  localparam int unsigned DIV_Q_W   = FRAC_WIDTH;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_Q_W);
  localparam int unsigned MUL_A_W   = LVL_W + 1;
  localparam int unsigned MUL_B_W   = LVL_W;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W);

  // Register reset values.
  localparam logic [TIME_W-1:0] ATTACK_RST  = '0;
  localparam logic [TIME_W-1:0] DECAY_RST   = TIME_W'(ONE);
  localparam logic [LVL_W-1:0]  SUSTAIN_RST = LVL_W'((64'd2 << FRAC_WIDTH) / 5);
  localparam logic [TIME_W-1:0] RELEASE_RST = TIME_W'(ONE);
  localparam logic [LVL_W-1:0]  SDELTA_RST  = LVL_W'((64'd1 << FRAC_WIDTH) / 48000);
  localparam logic [BLEN_W-1:0] BLEN_RST    = BLEN_W'(1156);

  typedef enum logic [PH_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK  = 3'd0,
    REG_DECAY   = 3'd1,
    REG_SUSTAIN = 3'd2,
    REG_RELEASE = 3'd3,
    REG_SDELTA  = 3'd4,
    REG_BLEN    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;  // two's complement
    logic [MUL_B_W-1:0] b;  // unsigned
  } mul_req_t;

endpackage

FILE: hdl/ase_if.sv
interface ase_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [ase_pkg::SMP_W-1:0] sample_in;
  logic                             gate;
  logic                             go_idle;

  modport source (output valid, sample_in, gate, go_idle, input ready);
  modport sink   (input valid, sample_in, gate, go_idle, output ready);
endinterface

interface ase_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [ase_pkg::SMP_W-1:0] sample_out;
  logic        [ase_pkg::LVL_W-1:0] level;
  logic        [ase_pkg::PH_W-1:0]  phase;

  modport source (output valid, sample_out, level, phase, input ready);
  modport sink   (input valid, sample_out, level, phase, output ready);
endinterface

interface ase_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ase_pkg::CFG_IDX_W-1:0]     index;
  logic [ase_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/ase_serial_div.sv
// Restoring divider, one quotient bit per cycle. Expects num < den.
module ase_serial_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ase_pkg::div_req_t              req_i,
  output logic                           done_o,
  output logic [ase_pkg::DIV_Q_W-1:0]    quot_o
);

  localparam logic [ase_pkg::DIV_CNT_W-1:0] LAST =
    ase_pkg::DIV_CNT_W'(ase_pkg::DIV_Q_W - 1);

  logic                            busy_q;
  logic                            done_q;
  logic [ase_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [ase_pkg::TIME_W-1:0]      rem_q;
  logic [ase_pkg::TIME_W-1:0]      den_q;
  logic [ase_pkg::DIV_Q_W-1:0]     quot_q;
  logic [ase_pkg::TIME_W:0]        shl;
  logic [ase_pkg::TIME_W:0]        diff;
  logic                            fits;

  assign shl  = {rem_q, 1'b0};
  assign diff = shl - {1'b0, den_q};
  assign fits = !diff[ase_pkg::TIME_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.num;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[ase_pkg::TIME_W-1:0] : shl[ase_pkg::TIME_W-1:0];
      quot_q <= {quot_q[ase_pkg::DIV_Q_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: hdl/ase_serial_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// Signed a times unsigned b; the product shifts right into lo_q.
module ase_serial_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ase_pkg::mul_req_t            req_i,
  output logic                         done_o,
  output logic [ase_pkg::MUL_P_W-1:0]  prod_o
);

  localparam int unsigned AW = ase_pkg::MUL_A_W;
  localparam int unsigned BW = ase_pkg::MUL_B_W;
  localparam logic [ase_pkg::MUL_CNT_W-1:0] LAST = ase_pkg::MUL_CNT_W'(BW - 1);

  logic                            busy_q;
  logic                            done_q;
  logic [ase_pkg::MUL_CNT_W-1:0]   cnt_q;
  logic [AW-1:0]                   a_q;
  logic [BW-1:0]                   b_q;
  logic [AW-1:0]                   hi_q;
  logic [BW-1:0]                   lo_q;
  logic [AW:0]                     sum;

  assign sum = {hi_q[AW-1], hi_q} + (b_q[0] ? {a_q[AW-1], a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q  <= req_i.a;
      b_q  <= req_i.b;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      hi_q <= sum[AW:1];
      lo_q <= {sum[0], lo_q[BW-1:1]};
      b_q  <= {1'b0, b_q[BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

FILE: hdl/adsr_envelope_scaler_unit.sv
// Sequence: an accepted item inside a block goes straight to the sample multiply. At a
//   block start the phase decision comes first; where a quotient is needed, attack runs
//   the divider, and decay or release the divider and then the envelope multiply.
// Throughput: one item at a time; a result left unread holds the next one back.
// Reset: rst_ni asynchronously clears to idle phase, zero level and time, default registers.
module adsr_envelope_scaler_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  ase_in_if.sink    in_i,
  ase_cfg_if.sink   cfg_i,
  ase_out_if.source out_o
);

  localparam int unsigned FW = ase_pkg::FRAC_WIDTH;
  localparam int unsigned LW = ase_pkg::LVL_W;
  localparam int unsigned TW = ase_pkg::TIME_W;
  localparam int unsigned SW = ase_pkg::SMP_W;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_START   = 7'b0000010,
    ST_DIV     = 7'b0000100,
    ST_ENV_MUL = 7'b0001000,
    ST_SMP_GO  = 7'b0010000,
    ST_SMP_MUL = 7'b0100000,
    ST_OUT     = 7'b1000000
  } state_e;

  // Which envelope formula the pending quotient feeds.
  typedef enum logic [1:0] {
    OP_ATTACK  = 2'd0,
    OP_DECAY   = 2'd1,
    OP_RELEASE = 2'd2
  } env_op_e;

  // Configuration registers.
  logic [TW-1:0]                  attack_q;
  logic [TW-1:0]                  decay_q;
  logic [LW-1:0]                  sustain_q;
  logic [TW-1:0]                  release_q;
  logic [LW-1:0]                  sdelta_q;
  logic [ase_pkg::BLEN_W-1:0]     blen_q;

  // Envelope state.
  state_e                         state_q, state_d;
  ase_pkg::phase_e                phase_q;
  logic [TW-1:0]                  elapsed_q;
  logic [LW-1:0]                  level_q;
  logic [LW-1:0]                  rel_from_q;
  logic [ase_pkg::POS_W-1:0]      pos_q;
  env_op_e                        op_q;

  // Captured input item.
  logic [SW-1:0]                  smp_q;
  logic                           gate_q;
  logic                           idle_req_q;

  // Output register.
  logic                           out_valid_q;
  logic [SW-1:0]                  out_smp_q;
  logic [LW-1:0]                  out_level_q;
  logic [ase_pkg::PH_W-1:0]       out_phase_q;

  // Arithmetic units.
  ase_pkg::div_req_t              div_req;
  ase_pkg::mul_req_t              mul_req;
  logic                           div_done;
  logic                           mul_done;
  logic [ase_pkg::DIV_Q_W-1:0]    quot;
  logic [ase_pkg::MUL_P_W-1:0]    prod;
  logic [LW-1:0]                  prod_lvl;

  // Helpers.
  logic [LW-1:0]                  sus_sat;
  logic [ase_pkg::BLEN_W-1:0]     blen_eff;
  logic [ase_pkg::BLEN_W-1:0]     pos_inc;
  logic [TW:0]                    el_sum;
  logic [TW-1:0]                  el_next;
  logic                           in_acc;
  logic                           out_load;

  // Block-start decision.
  ase_pkg::phase_e                st_ph;
  logic [TW-1:0]                  st_el;
  logic [LW-1:0]                  st_rf;
  logic [LW-1:0]                  st_lvl;
  logic                           st_div;
  env_op_e                        st_op;
  logic [TW-1:0]                  st_den;

  assign in_acc      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // Saturate sustain at unity and clamp the block length into 1..4096.
  assign sus_sat  = (sustain_q > ase_pkg::ONE) ? ase_pkg::ONE : sustain_q;
  assign blen_eff = (blen_q == '0) ? ase_pkg::BLEN_W'(1) :
                    (blen_q > ase_pkg::MAX_BLOCK) ? ase_pkg::MAX_BLOCK : blen_q;
  assign pos_inc  = {1'b0, pos_q} + ase_pkg::BLEN_W'(1);

  // Elapsed time advances per item and sticks at all ones.
  assign el_sum  = {1'b0, elapsed_q} + {{(TW + 1 - LW){1'b0}}, sdelta_q};
  assign el_next = el_sum[TW] ? '1 : el_sum[TW-1:0];

  assign prod_lvl = prod[FW +: LW];

  // Phase machine at a block start: idle request, gate release, then the
  // phase's own rule. Either the level is known now or a quotient is needed.
  always_comb begin
    st_ph  = idle_req_q ? ase_pkg::PH_IDLE : phase_q;
    st_el  = elapsed_q;
    st_rf  = rel_from_q;
    st_lvl = '0;
    st_div = 1'b0;
    st_op  = OP_ATTACK;
    st_den = attack_q;
    if (!gate_q && (st_ph == ase_pkg::PH_ATTACK || st_ph == ase_pkg::PH_DECAY ||
                    st_ph == ase_pkg::PH_SUSTAIN)) begin
      st_rf = level_q;
      st_el = '0;
      st_ph = ase_pkg::PH_RELEASE;
    end
    unique case (st_ph)
      ase_pkg::PH_ATTACK: begin
        if (st_el >= attack_q) begin
          st_lvl = ase_pkg::ONE;
          st_ph  = ase_pkg::PH_DECAY;
          st_el  = '0;
        end else begin
          st_div = 1'b1;
          st_op  = OP_ATTACK;
          st_den = attack_q;
        end
      end
      ase_pkg::PH_DECAY: begin
        if (st_el >= decay_q) begin
          st_lvl = sus_sat;
          st_ph  = ase_pkg::PH_SUSTAIN;
          st_el  = '0;
        end else begin
          st_div = 1'b1;
          st_op  = OP_DECAY;
          st_den = decay_q;
        end
      end
      ase_pkg::PH_SUSTAIN: begin
        st_lvl = sus_sat;
      end
      ase_pkg::PH_RELEASE: begin
        // Retrigger first; a zero release time still ends in idle.
        if (gate_q) begin
          st_ph = ase_pkg::PH_ATTACK;
          st_el = '0;
        end
        if (st_el >= release_q) begin
          st_lvl = '0;
          st_ph  = ase_pkg::PH_IDLE;
        end else begin
          st_div = 1'b1;
          st_op  = OP_RELEASE;
          st_den = release_q;
        end
      end
      default: begin
        st_ph  = gate_q ? ase_pkg::PH_ATTACK : ase_pkg::PH_IDLE;
        if (gate_q) begin
          st_el = '0;
        end
        st_lvl = '0;
      end
    endcase
  end

  // Launch the divider from the block start.
  always_comb begin
    div_req.start = (state_q == ST_START) && st_div;
    div_req.num   = st_el;
    div_req.den   = st_den;
  end

  // Share the multiplier: decay and release shaping right after the quotient, then the
  // sample times the block level.
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = {{(ase_pkg::MUL_A_W - SW){smp_q[SW-1]}}, smp_q};
    mul_req.b     = level_q;
    if (state_q == ST_DIV && div_done && op_q != OP_ATTACK) begin
      mul_req.start = 1'b1;
      if (op_q == OP_DECAY) begin
        mul_req.a = {1'b0, ase_pkg::ONE - sus_sat};
        mul_req.b = {1'b0, quot};
      end else begin
        mul_req.a = {1'b0, rel_from_q};
        mul_req.b = ase_pkg::ONE - {1'b0, quot};
      end
    end else if (state_q == ST_SMP_GO) begin
      mul_req.start = 1'b1;
    end
  end

  ase_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  ase_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (prod)
  );

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_acc) state_d = (pos_q == '0) ? ST_START : ST_SMP_GO;
      ST_START:   state_d = st_div ? ST_DIV : ST_SMP_GO;
      ST_DIV:     if (div_done) state_d = (op_q == OP_ATTACK) ? ST_SMP_GO : ST_ENV_MUL;
      ST_ENV_MUL: if (mul_done) state_d = ST_SMP_GO;
      ST_SMP_GO:  state_d = ST_SMP_MUL;
      ST_SMP_MUL: if (mul_done) state_d = ST_OUT;
      ST_OUT:     if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Configuration writes, envelope state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q    <= ase_pkg::ATTACK_RST;
      decay_q     <= ase_pkg::DECAY_RST;
      sustain_q   <= ase_pkg::SUSTAIN_RST;
      release_q   <= ase_pkg::RELEASE_RST;
      sdelta_q    <= ase_pkg::SDELTA_RST;
      blen_q      <= ase_pkg::BLEN_RST;
      state_q     <= ST_IDLE;
      phase_q     <= ase_pkg::PH_IDLE;
      elapsed_q   <= '0;
      level_q     <= '0;
      rel_from_q  <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_i.valid && cfg_i.ready) begin
        unique case (ase_pkg::cfg_reg_e'(cfg_i.index))
          ase_pkg::REG_ATTACK:  attack_q  <= cfg_i.data[TW-1:0];
          ase_pkg::REG_DECAY:   decay_q   <= cfg_i.data[TW-1:0];
          ase_pkg::REG_SUSTAIN: sustain_q <= cfg_i.data[LW-1:0];
          ase_pkg::REG_RELEASE: release_q <= cfg_i.data[TW-1:0];
          ase_pkg::REG_SDELTA:  sdelta_q  <= cfg_i.data[LW-1:0];
          ase_pkg::REG_BLEN:    blen_q    <= cfg_i.data[ase_pkg::BLEN_W-1:0];
          default: ;
        endcase
      end

      // Commit the block-start decision.
      if (state_q == ST_START) begin
        phase_q    <= st_ph;
        elapsed_q  <= st_el;
        rel_from_q <= st_rf;
        if (!st_div) begin
          level_q <= st_lvl;
        end
      end

      // Attack level is the quotient itself.
      if (state_q == ST_DIV && div_done && op_q == OP_ATTACK) begin
        level_q <= {1'b0, quot};
      end

      if (state_q == ST_ENV_MUL && mul_done) begin
        level_q <= (op_q == OP_DECAY) ? ase_pkg::ONE - prod_lvl : prod_lvl;
      end

      // Advance time and the block position once per item.
      if (state_q == ST_SMP_GO) begin
        elapsed_q <= el_next;
        pos_q     <= (pos_inc >= blen_eff) ? '0 : pos_inc[ase_pkg::POS_W-1:0];
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item capture, pending operation and result payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q      <= in_i.sample_in;
      gate_q     <= in_i.gate;
      idle_req_q <= in_i.go_idle;
    end
    if (state_q == ST_START) begin
      op_q <= st_op;
    end
    if (out_load) begin
      out_smp_q   <= prod[FW +: SW];
      out_level_q <= level_q;
      out_phase_q <= phase_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_smp_q;
  assign out_o.level      = out_level_q;
  assign out_o.phase      = out_phase_q;

endmodule

FILE: hdl/ase_checker.sv
`include "assert_macros.svh"

module ase_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [ase_pkg::SMP_W-1:0] out_sample,
  input logic        [ase_pkg::LVL_W-1:0] out_level,
  input logic        [ase_pkg::PH_W-1:0]  out_phase
);

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  // Hold a stalled result.
  `ASE_ASSERT(a_out_hold, out_stall |=> out_valid)
  `ASE_ASSERT(a_out_stable, out_stall |=> $stable({out_sample, out_level, out_phase}))

  // One item in flight: an accept closes the input until its result is done.
  `ASE_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready)

  // An idle envelope scales to silence.
  `ASE_ASSERT(a_idle_silent, out_valid && out_phase == ase_pkg::PH_IDLE |-> out_level == '0)

  // No result during reset.
  `ASE_ASSERT_RST(a_reset_quiet, !rst_ni |-> !out_valid)

endmodule

bind adsr_envelope_scaler_unit ase_checker u_ase_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_sample (out_o.sample_out),
  .out_level  (out_o.level),
  .out_phase  (out_o.phase)
);
